// ===== hdl/rtct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_pkg
// Shared types and constants of the region thread count tuner.
// ----------------------------------------------------------------------------
package rtct_pkg;

  localparam int unsigned MaxRegionsDef = 64;
  localparam int unsigned ThreadBitsDef = 10;

  localparam logic [8:0]  CoreCountRst   = 9'd8;
  localparam logic [8:0]  StartThreadsRst = 9'd2;

  localparam logic [1:0] RegCoreCount   = 2'd0;
  localparam logic [1:0] RegStartThreads = 2'd1;
  localparam logic [1:0] RegMetricMode  = 2'd2;
  localparam logic [1:0] RegSwitchThr   = 2'd3;

  typedef enum logic [2:0] {
    PhStart  = 3'd0,
    PhRepeat = 3'd1,
    PhS0     = 3'd2,
    PhS1     = 3'd3,
    PhS2     = 3'd4,
    PhEndThr = 3'd5,
    PhEnd    = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    StIdle,
    StSrch,
    StSrchCmp,
    StDecide,
    StPRd,
    StPCalc,
    StCRd,
    StCCalc,
    StOut
  } state_e;

  typedef struct packed {
    logic load_in;
    logic set_hit;
    logic idx_inc;
    logic new_slot;
    logic full_load;
    logic sel_cur;
    logic p_update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic srch_end;
    logic key_hit;
    logic tbl_full;
  } stat_t;

  typedef struct packed {
    logic [8:0]  core_count;
    logic [8:0]  start_threads;
    logic        metric_mode;
    logic [31:0] switch_threshold;
  } cfg_t;

endpackage

// ===== hdl/rtct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_ctrl
// Sequencer: key search, slot assignment, previous and current region passes.
// ----------------------------------------------------------------------------
module rtct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rtct_pkg::stat_t stat_i,
  output rtct_pkg::cmd_t  cmd_o
);
  import rtct_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_valid_i) state_d = StSrch;
      StSrch:    state_d = stat_i.srch_end ? StDecide : StSrchCmp;
      StSrchCmp: state_d = stat_i.key_hit ? StPRd : StSrch;
      StDecide:  state_d = stat_i.tbl_full ? StOut : StPRd;
      StPRd:     state_d = StPCalc;
      StPCalc:   state_d = StCRd;
      StCRd:     state_d = StCCalc;
      StCCalc:   state_d = StOut;
      StOut:     if (out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StSrchCmp: begin
        cmd_o.set_hit = stat_i.key_hit;
        cmd_o.idx_inc = !stat_i.key_hit;
      end
      StDecide: begin
        cmd_o.full_load = stat_i.tbl_full;
        cmd_o.new_slot  = !stat_i.tbl_full;
      end
      StPCalc: cmd_o.p_update = 1'b1;
      StCRd:   cmd_o.sel_cur  = 1'b1;
      StCCalc: cmd_o.out_load = 1'b1;
      StOut:   out_valid_o    = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hdl/rtct_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_dp
// Datapath: key table, per-region search records, scoring and search step.
// ----------------------------------------------------------------------------
module rtct_dp #(
  parameter int unsigned MAX_REGIONS = rtct_pkg::MaxRegionsDef,
  parameter int unsigned THREAD_BITS = rtct_pkg::ThreadBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtct_pkg::cfg_t  cfg_i,
  input  rtct_pkg::cmd_t  cmd_i,
  output rtct_pkg::stat_t stat_o,
  input  logic [127:0]    in_data_i,
  output logic [23:0]     out_data_o
);
  import rtct_pkg::*;

  localparam int unsigned SlotW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned T     = THREAD_BITS;
  localparam logic [T-1:0] TMax = '1;

  typedef struct packed {
    phase_e      ph;
    logic        met;
    logic [T-1:0] trial;
    logic [T-1:0] last;
    logic [T-1:0] step;
    logic [T-1:0] best;
    logic [63:0] bscore;
    logic        bturbo;
    logic [31:0] toff;
    logic [31:0] ton;
  } rec_t;

  function automatic logic [T-1:0] tsat(input logic [31:0] v);
    tsat = (v > {{(32-T){1'b0}}, TMax}) ? TMax : v[T-1:0];
  endfunction

  logic [63:0] key_q;
  logic [31:0] t_q, e_q;
  logic [63:0] prod_q;
  logic [CntW-1:0] idx_q, used_q;
  logic [SlotW-1:0] prev_slot_q, cur_q;
  logic prev_valid_q, new_q, ew_q, btp_q;
  logic [63:0] key_rd_q;
  rec_t rec_rd_q;
  logic [23:0] out_q;

  logic [63:0] key_mem [MAX_REGIONS];
  rec_t        rec_mem [MAX_REGIONS];

  rec_t init_rec, adv_rec, wr_rec;
  logic adv_en, adv_ew, rec_we;
  logic [SlotW-1:0] rd_addr, wr_addr, used_slot;

  logic [23:0] c_out;
  logic [31:0] core_w;
  logic [9:0]  core_sat;
  assign core_w   = 32'(cfg_i.core_count);
  assign core_sat = (core_w > 32'd1023) ? 10'd1023 : core_w[9:0];

  assign used_slot = used_q[SlotW-1:0];
  assign stat_o.srch_end = (idx_q >= used_q);
  assign stat_o.key_hit  = (key_rd_q == key_q);
  assign stat_o.tbl_full = (used_q >= CntW'(MAX_REGIONS));

  // The product is rebuilt every cycle from the held inputs; it is settled
  // long before the previous region is scored.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q <= in_data_i[63:0];
      t_q   <= in_data_i[95:64];
      e_q   <= in_data_i[127:96];
    end
    prod_q <= 64'(t_q) * 64'(e_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.new_slot) key_mem[used_slot] <= key_q;
    key_rd_q <= key_mem[idx_q[SlotW-1:0]];
  end

  assign rd_addr = cmd_i.sel_cur ? cur_q : prev_slot_q;
  assign rec_we  = cmd_i.new_slot || (cmd_i.p_update && adv_en);
  assign wr_addr = cmd_i.new_slot ? used_slot : prev_slot_q;
  assign wr_rec  = cmd_i.new_slot ? init_rec : adv_rec;

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[wr_addr] <= wr_rec;
    rec_rd_q <= rec_mem[rd_addr];
  end

  // A new slot goes straight to repeat; its start phase only blocks scoring
  // of the previous region on this word, which new_q covers.
  always_comb begin
    init_rec        = '0;
    init_rec.ph     = PhRepeat;
    init_rec.met    = cfg_i.metric_mode;
    init_rec.trial  = tsat(32'(cfg_i.core_count));
  end

  always_comb begin
    rec_t r;
    logic [63:0] score;
    logic [T-1:0] stp;
    phase_e ph_eff;
    r      = rec_rd_q;
    adv_rec = r;
    adv_ew = 1'b0;
    score  = r.met ? prod_q : {32'b0, t_q};
    ph_eff = r.ph;
    if (r.met && (prod_q == 64'd0)) begin
      ph_eff      = PhRepeat;
      adv_rec.met = 1'b0;
    end
    stp = '0;
    case (ph_eff)
      PhRepeat: begin
        adv_rec.ph    = PhS0;
        adv_rec.trial = tsat(32'(cfg_i.start_threads));
        adv_rec.last  = tsat(32'(cfg_i.start_threads));
      end
      PhS0: begin
        adv_rec.bscore = score;
        adv_rec.best   = r.trial;
        adv_rec.trial  = tsat(32'(r.trial) << 1);
        adv_rec.ph     = PhS1;
      end
      PhS1: begin
        if (score < r.bscore) begin
          adv_rec.bscore = score;
          adv_rec.best   = r.trial;
          if ((32'(r.trial) << 1) <= 32'(cfg_i.core_count)) begin
            adv_rec.last  = r.trial;
            adv_rec.trial = tsat(32'(r.trial) << 1);
          end else begin
            stp = r.last >> 1;
            adv_rec.step = stp;
            if (stp >= T'(2)) begin
              adv_rec.trial = (r.trial > stp) ? r.trial - stp : '0;
              adv_rec.ph    = PhS2;
            end else begin
              adv_rec.bturbo = 1'b1;
              adv_rec.toff   = t_q;
              adv_rec.ph     = PhEndThr;
            end
          end
        end else if (32'(r.best) == 32'(cfg_i.core_count >> 1)) begin
          adv_rec.bturbo = 1'b1;
          adv_rec.toff   = t_q;
          adv_rec.ph     = PhEndThr;
        end else begin
          stp = r.last >> 1;
          adv_rec.step = stp;
          if (stp >= T'(2)) begin
            adv_rec.trial = tsat(32'(r.trial) + 32'(stp));
            adv_rec.ph    = PhS2;
          end else begin
            adv_rec.bturbo = 1'b1;
            adv_rec.toff   = t_q;
            adv_rec.ph     = PhEndThr;
          end
        end
      end
      PhS2: begin
        if (!(r.bscore < score)) begin
          adv_rec.best   = r.trial;
          adv_rec.bscore = score;
        end
        stp = r.step >> 1;
        adv_rec.step = stp;
        if (stp >= T'(2)) begin
          adv_rec.trial = tsat(32'(r.trial) + 32'(stp));
        end else begin
          adv_rec.bturbo = 1'b1;
          adv_rec.toff   = t_q;
          adv_rec.ph     = PhEndThr;
        end
      end
      PhEndThr: begin
        adv_rec.ph  = PhEnd;
        adv_rec.ton = t_q;
        if (r.bscore < score) begin
          adv_rec.bturbo = 1'b0;
          adv_ew         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign adv_en = prev_valid_q && !new_q && (rec_rd_q.ph != PhEnd);

  always_comb begin
    rec_t c;
    logic [T-1:0] thr;
    logic [31:0] thr_w;
    logic bw;
    c   = rec_rd_q;
    bw  = 1'b0;
    thr = tsat(32'(cfg_i.core_count));
    if (prev_valid_q) begin
      if (new_q) begin
        bw = (c.bturbo != btp_q);
      end else begin
        case (c.ph)
          PhEnd: begin
            bw = (!btp_q && c.bturbo &&
                  ((33'(c.ton) + 33'(cfg_i.switch_threshold)) < 33'(c.toff))) ||
                 (btp_q && !c.bturbo &&
                  ((33'(c.toff) + 33'(cfg_i.switch_threshold)) < 33'(c.ton)));
            thr = c.best;
          end
          PhEndThr: begin
            bw  = (c.bturbo != btp_q) && (c.toff > cfg_i.switch_threshold);
            thr = c.best;
          end
          default: begin
            bw  = (c.bturbo != btp_q);
            thr = c.trial;
          end
        endcase
      end
    end
    // Core count is used unsaturated for the first word and for a new slot.
    thr_w = (!prev_valid_q || new_q) ? 32'(cfg_i.core_count) : 32'(thr);
    out_data_o = out_q;
    c_out = '0;
    c_out[9:0]   = (thr_w > 32'd1023) ? 10'd1023 : thr_w[9:0];
    c_out[10]    = ew_q;
    c_out[11]    = ew_q && c.bturbo;
    c_out[12]    = bw;
    c_out[13]    = bw && c.bturbo;
    c_out[19:14] = 6'(32'(cur_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_hit) cur_q <= idx_q[SlotW-1:0];
    if (cmd_i.new_slot) cur_q <= used_slot;
    if (cmd_i.p_update) begin
      ew_q  <= adv_en && adv_ew;
      btp_q <= adv_en ? adv_rec.bturbo : rec_rd_q.bturbo;
    end
    if (cmd_i.out_load) begin
      out_q <= c_out;
    end else if (cmd_i.full_load) begin
      out_q <= {3'b000, 1'b1, 10'd0, core_sat};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      used_q       <= '0;
      prev_slot_q  <= '0;
      prev_valid_q <= 1'b0;
      new_q        <= 1'b0;
    end else begin
      if (cmd_i.load_in) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + CntW'(1);
      if (cmd_i.set_hit) new_q <= 1'b0;
      if (cmd_i.new_slot) begin
        used_q <= used_q + CntW'(1);
        new_q  <= 1'b1;
      end
      if (cmd_i.out_load) begin
        prev_slot_q  <= cur_q;
        prev_valid_q <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MAX_REGIONS)) else $error("slot count beyond table depth");
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.new_slot |=> used_q == $past(used_q) + CntW'(1))
    else $error("slot count did not advance");
  a_cur_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> CntW'(cur_q) < used_q) else $error("current slot unassigned");
  a_prev_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> prev_valid_q) else $error("previous region not recorded");
`endif

endmodule

// ===== hdl/region_thread_count_tuner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_thread_count_tuner
// Per-region thread count and turbo search, stream in and out, APB registers.
// ----------------------------------------------------------------------------
// Search: the key is compared with each slot in use in turn; a found key stops
// the scan at its slot, a new key gets the next free slot, and a full table
// skips the region passes and returns the core count.
// Throughput: one word at a time; the next input is taken in the cycle after the
// result word has been taken.
// Reset: asynchronous active low; clears the table fill count and the
// previous region; registers return to core 8, start 2, metric 0, threshold 0.
module region_thread_count_tuner #(
  parameter int unsigned MAX_REGIONS = rtct_pkg::MaxRegionsDef,
  parameter int unsigned THREAD_BITS = rtct_pkg::ThreadBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // region_key[63:0], elapsed_ticks[95:64], energy_units[127:96]
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // thread_count[9:0], early_boost_write[10], early_boost_value[11],
  // boost_write[12], boost_value[13], region_slot[19:14], table_full[20]
  output logic [23:0]  m_axis_tdata_o,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [3:0]   paddr_i,
  input  logic [31:0]  pwdata_i,
  output logic [31:0]  prdata_o,
  output logic         pready_o
);
  import rtct_pkg::*;

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.core_count       <= CoreCountRst;
      cfg_q.start_threads    <= StartThreadsRst;
      cfg_q.metric_mode      <= 1'b0;
      cfg_q.switch_threshold <= '0;
    end else if (wr_en) begin
      case (paddr_i[3:2])
        RegCoreCount:    cfg_q.core_count       <= pwdata_i[8:0];
        RegStartThreads: cfg_q.start_threads    <= pwdata_i[8:0];
        RegMetricMode:   cfg_q.metric_mode      <= pwdata_i[0];
        RegSwitchThr:    cfg_q.switch_threshold <= pwdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[3:2])
      RegCoreCount:    prdata_o = 32'(cfg_q.core_count);
      RegStartThreads: prdata_o = 32'(cfg_q.start_threads);
      RegMetricMode:   prdata_o = 32'(cfg_q.metric_mode);
      RegSwitchThr:    prdata_o = cfg_q.switch_threshold;
      default:         prdata_o = '0;
    endcase
  end

  rtct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rtct_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .THREAD_BITS (THREAD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata_i),
    .out_data_o (m_axis_tdata_o)
  );

endmodule

// ===== sim/region_thread_count_tuner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_thread_count_tuner_test
// Self-checking bench for the region thread count tuner. Region entry words
// go in over the slave stream with bursty timing. A local model of the key
// table and the per-region search predicts every result word. A checker
// compares each result word, field by field, while the receiver stalls on
// its own pattern. The registers are swept over several settings, including
// their extremes, and the run ends by filling the key table until it is full.
// ----------------------------------------------------------------------------
module region_thread_count_tuner_test;
  import rtct_pkg::*;

  localparam int unsigned Regions   = MaxRegionsDef;
  localparam logic [9:0]  ThreadMax = 10'h3FF;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic       table_full;
    logic [5:0] region_slot;
    logic       boost_value;
    logic       boost_write;
    logic       early_value;
    logic       early_write;
    logic [9:0] thread_count;
  } tune_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [23:0]  m_axis_tdata_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [3:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  region_thread_count_tuner uut (.*);

  always #1 clk_i = ~clk_i;

  // Register copies held by the model.
  logic [8:0]  m_cores = CoreCountRst;
  logic [8:0]  m_start = StartThreadsRst;
  logic        m_metric = 1'b0;
  logic [31:0] m_thresh = '0;

  // Model of the key table and the search state of each region.
  logic [63:0] keys [Regions];
  int unsigned used_slots = 0;
  int unsigned prev_slot = 0;
  bit          prev_valid = 0;
  phase_e      phase [Regions];
  logic        slot_metric [Regions];
  logic        best_turbo [Regions];
  logic [9:0]  trial_thr [Regions];
  logic [9:0]  last_thr [Regions];
  logic [9:0]  step [Regions];
  logic [9:0]  best_thr [Regions];
  logic [63:0] best_score [Regions];
  logic [31:0] t_off [Regions];
  logic [31:0] t_on [Regions];

  tune_result_t pending_results[$];
  int unsigned  errors = 0;
  int unsigned  words_sent = 0;
  int unsigned  words_seen = 0;
  int unsigned  full_hits = 0;
  int unsigned  boost_writes = 0;
  int unsigned  cycles = 0;
  int unsigned  stall_mode = 0;
  logic [63:0]  hot_keys [4];

  initial begin
    for (int i = 0; i < Regions; i++) begin
      last_thr[i] = '0; step[i] = '0; best_thr[i] = '0; best_score[i] = '0;
      phase[i] = PhStart; slot_metric[i] = 0; best_turbo[i] = 0;
      trial_thr[i] = '0; t_off[i] = '0; t_on[i] = '0; keys[i] = '0;
    end
  end

  function automatic logic [9:0] sat_threads(logic [63:0] v);
    return (v > ThreadMax) ? ThreadMax : v[9:0];
  endfunction

  function automatic void begin_turbo_trial(int unsigned p, logic [31:0] t);
    best_turbo[p] = 1'b1;
    t_off[p] = t;
    phase[p] = PhEndThr;
  endfunction

  function automatic tune_result_t predict_entry(logic [63:0] key, logic [31:0] t,
                                                 logic [31:0] e);
    int          cur;
    int unsigned p;
    logic [9:0]  thr;
    logic [63:0] score;
    bit          ew, ev, bw, bv;
    tune_result_t r;
    cur = -1; ew = 0; ev = 0; bw = 0; bv = 0; p = 0;
    for (int i = 0; i < used_slots; i++)
      if (cur < 0 && keys[i] == key) cur = i;
    if (cur < 0) begin
      if (used_slots >= Regions) begin
        r = '0;
        r.thread_count = {1'b0, m_cores};
        r.table_full = 1'b1;
        return r;
      end
      cur = used_slots++;
      keys[cur] = key;
      phase[cur] = PhStart;
      slot_metric[cur] = m_metric;
      trial_thr[cur] = {1'b0, m_cores};
      best_turbo[cur] = 0;
      t_off[cur] = '0;
      t_on[cur] = '0;
    end
    if (!prev_valid) begin
      phase[cur] = PhRepeat;
      prev_slot = cur;
      prev_valid = 1;
      thr = {1'b0, m_cores};
    end else begin
      p = prev_slot;
      if (phase[p] != PhEnd && phase[cur] != PhStart) begin
        score = {32'd0, t};
        if (slot_metric[p]) begin
          score = 64'(t) * 64'(e);
          // A zero product drops the region back to a time-only search.
          if (score == 0) begin
            phase[p] = PhRepeat;
            slot_metric[p] = 0;
          end
        end
        case (phase[p])
          PhRepeat: begin
            phase[p] = PhS0;
            trial_thr[p] = sat_threads(64'(m_start));
            last_thr[p] = trial_thr[p];
          end
          PhS0: begin
            best_score[p] = score;
            best_thr[p] = trial_thr[p];
            trial_thr[p] = sat_threads(64'(trial_thr[p]) * 2);
            phase[p] = PhS1;
          end
          PhS1: begin
            if (score < best_score[p]) begin
              best_score[p] = score;
              best_thr[p] = trial_thr[p];
              if (64'(trial_thr[p]) * 2 <= 64'(m_cores)) begin
                last_thr[p] = trial_thr[p];
                trial_thr[p] = sat_threads(64'(trial_thr[p]) * 2);
              end else begin
                step[p] = last_thr[p] / 2;
                if (step[p] >= 2) begin
                  trial_thr[p] = (trial_thr[p] > step[p]) ? trial_thr[p] - step[p] : '0;
                  phase[p] = PhS2;
                end else begin
                  begin_turbo_trial(p, t);
                end
              end
            end else if (best_thr[p] == 10'(m_cores / 2)) begin
              begin_turbo_trial(p, t);
            end else begin
              step[p] = last_thr[p] / 2;
              if (step[p] >= 2) begin
                trial_thr[p] = sat_threads(64'(trial_thr[p]) + 64'(step[p]));
                phase[p] = PhS2;
              end else begin
                begin_turbo_trial(p, t);
              end
            end
          end
          PhS2: begin
            if (!(best_score[p] < score)) begin
              best_thr[p] = trial_thr[p];
              best_score[p] = score;
            end
            step[p] = step[p] / 2;
            if (step[p] >= 2) trial_thr[p] = sat_threads(64'(trial_thr[p]) + 64'(step[p]));
            else begin_turbo_trial(p, t);
          end
          PhEndThr: begin
            phase[p] = PhEnd;
            t_on[p] = t;
            if (best_score[p] < score) begin
              best_turbo[p] = 0;
              ew = 1;
              ev = best_turbo[cur];
            end
          end
          default: ;
        endcase
      end
      case (phase[cur])
        PhEnd: begin
          if ((!best_turbo[p] && best_turbo[cur] &&
               64'(t_on[cur]) + 64'(m_thresh) < 64'(t_off[cur])) ||
              (best_turbo[p] && !best_turbo[cur] &&
               64'(t_off[cur]) + 64'(m_thresh) < 64'(t_on[cur]))) begin
            bw = 1; bv = best_turbo[cur];
          end
          thr = best_thr[cur];
        end
        PhEndThr: begin
          if (best_turbo[cur] != best_turbo[p] && t_off[cur] > m_thresh) begin
            bw = 1; bv = best_turbo[cur];
          end
          thr = best_thr[cur];
        end
        PhStart: begin
          phase[cur] = PhRepeat;
          if (best_turbo[cur] != best_turbo[p]) begin
            bw = 1; bv = best_turbo[cur];
          end
          thr = {1'b0, m_cores};
        end
        default: begin
          if (best_turbo[cur] != best_turbo[p]) begin
            bw = 1; bv = best_turbo[cur];
          end
          thr = trial_thr[cur];
        end
      endcase
      prev_slot = cur;
    end
    r.thread_count = thr;
    r.early_write = ew;
    r.early_value = ew & ev;
    r.boost_write = bw;
    r.boost_value = bw & bv;
    r.region_slot = cur[5:0];
    r.table_full = 1'b0;
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel_i = 1'b1; pwrite_i = 1'b1; penable_i = 1'b0;
    paddr_i = {idx, 2'b00}; pwdata_i = value;
    @(negedge clk_i);
    penable_i = 1'b1;
    @(negedge clk_i);
    psel_i = 1'b0; penable_i = 1'b0; pwrite_i = 1'b0;
    case (idx)
      RegCoreCount:    m_cores = value[8:0];
      RegStartThreads: m_start = value[8:0];
      RegMetricMode:   m_metric = value[0];
      default:         m_thresh = value;
    endcase
  endtask

  task automatic configure(logic [8:0] cores, logic [8:0] start, logic metric,
                           logic [31:0] thresh);
    write_reg(RegCoreCount, {23'd0, cores});
    write_reg(RegStartThreads, {23'd0, start});
    write_reg(RegMetricMode, {31'd0, metric});
    write_reg(RegSwitchThr, thresh);
  endtask

  // Send one region entry word, then maybe leave a gap.
  task automatic send_entry(logic [63:0] key, logic [31:0] t, logic [31:0] e, int gap);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {e, t, key};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(predict_entry(key, t, e));
    words_sent++;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Gap before the next word: bursts of back-to-back words, then a pause.
  int unsigned burst_left = 0;
  function automatic int next_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      return $urandom_range(1, 8);
    end
    burst_left--;
    return 0;
  endfunction

  // The word just accepted keeps the block busy, so dropping valid at the
  // next falling edge cannot offer it a second time.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_ticks();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 3);
      default: return $urandom_range(100, 160);
    endcase
  endfunction

  function automatic logic [31:0] rand_energy();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom();
      default: return $urandom_range(1, 50);
    endcase
  endfunction

  // First region after reset, then the field extremes on the all-zero and all-one keys.
  task automatic test_first_and_extremes();
    send_entry(64'd0, '0, '0, 0);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, '0, 32'hFFFF_FFFF, 0);
    send_entry(64'd0, 32'hFFFF_FFFF, '0, 1);
    drain_results();
  endtask

  // Walk a region through the whole search in each metric.
  task automatic test_search_walk();
    configure(9'd16, 9'd2, 1'b0, 32'd5);
    for (int i = 0; i < 10; i++) send_entry(64'hA5A5, 32'd200 - 32'(i * 10), 32'd3, 0);
    drain_results();
    configure(9'd16, 9'd2, 1'b1, 32'd0);
    for (int i = 0; i < 8; i++) send_entry(64'h5A5A, 32'd50 + 32'(i), 32'd2, i % 2);
    // A zero energy word drops the time-energy region back to time only.
    send_entry(64'h5A5A, 32'd40, '0, 0);
    drain_results();
  endtask

  task automatic random_phase(int count, int new_key_pct);
    logic [63:0] key;
    for (int k = 0; k < 4; k++) hot_keys[k] = {$urandom(), $urandom()};
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < new_key_pct) key = {$urandom(), $urandom()};
      else if ($urandom_range(0, 9) == 0 && used_slots > 0)
        key = keys[$urandom_range(0, used_slots - 1)];
      else key = hot_keys[$urandom_range(0, 3)];
      send_entry(key, rand_ticks(), rand_energy(), next_gap());
    end
    drain_results();
  endtask

  task automatic test_random_settings();
    configure(9'd1, 9'd1, 1'b0, 32'd0);
    random_phase(120, 1);
    configure(9'd256, 9'd256, 1'b1, 32'hFFFF_FFFF);
    random_phase(120, 1);
    configure(9'd256, 9'd2, 1'b0, 32'd10);
    random_phase(140, 1);
    configure(9'd64, 9'd3, 1'b1, 32'd0);
    random_phase(140, 1);
    configure(9'd12, 9'd5, 1'b0, 32'd0);
    random_phase(140, 1);
    configure(9'($urandom_range(1, 256)), 9'($urandom_range(1, 256)),
              1'($urandom_range(0, 1)), 32'($urandom_range(0, 40)));
    random_phase(140, 2);
  endtask

  task automatic test_table_overflow();
    configure(9'd32, 9'd4, 1'b1, 32'd3);
    random_phase(200, 40);
  endtask

  // Receiver stall pattern, redrawn at random among four modes.
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready_i <= ((cycles % 7) < 3);
      default: m_axis_tready_i <= ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    tune_result_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run did not finish within the cycle limit", $time);
      $display("region_thread_count_tuner verification failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[20:0];
      words_seen++;
      if (got.table_full) full_hits++;
      if (got.boost_write || got.early_write) boost_writes++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.thread_count != want.thread_count) begin
          $display("%0t: thread_count expected %0d actual %0d", $time,
                   want.thread_count, got.thread_count);
          errors++;
        end
        if (got.early_write != want.early_write || got.early_value != want.early_value) begin
          $display("%0t: early boost expected %b%b actual %b%b", $time, want.early_write,
                   want.early_value, got.early_write, got.early_value);
          errors++;
        end
        if (got.boost_write != want.boost_write || got.boost_value != want.boost_value) begin
          $display("%0t: boost expected %b%b actual %b%b", $time, want.boost_write,
                   want.boost_value, got.boost_write, got.boost_value);
          errors++;
        end
        if (got.region_slot != want.region_slot) begin
          $display("%0t: region_slot expected %0d actual %0d", $time,
                   want.region_slot, got.region_slot);
          errors++;
        end
        if (got.table_full != want.table_full) begin
          $display("%0t: table_full expected %b actual %b", $time,
                   want.table_full, got.table_full);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);
    test_first_and_extremes();
    test_search_walk();
    test_random_settings();
    test_table_overflow();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Sent %0d region entries, checked %0d result words, %0d regions in the table.",
             words_sent, words_seen, used_slots);
    $display("Saw %0d full-table words and %0d words with boost writes.",
             full_hits, boost_writes);
    if (errors == 0) begin
      $display("region_thread_count_tuner verification clean");
    end else begin
      $display("region_thread_count_tuner verification failed");
    end
    $finish;
  end

endmodule
